// ===== sv/grid_reachability_search_assert.svh =====
// Assertion macros for the grid reachability search block.
// Included by the top level; no other dependencies.
`ifndef GRID_REACHABILITY_SEARCH_ASSERT_SVH
`define GRID_REACHABILITY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define GRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ((ante) |-> (cons))) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define GRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ((ante) |=> (cons))) \
        else $error(msg);
`else
`define GRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define GRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/grs_pkg.sv =====
// Shared types and constants for the grid reachability search block.
// No dependencies; imported by the top level, the controller and the datapath.
`default_nettype none

package grs_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;

    // input word layout
    localparam int COORD_W        = 4;
    localparam int ROW_BITS_W     = 16;
    localparam int ROW_INDEX_LSB  = 0;
    localparam int ROW_BITS_LSB   = 4;
    localparam int START_ROW_LSB  = 20;
    localparam int START_COL_LSB  = 24;
    localparam int END_ROW_LSB    = 28;
    localparam int END_COL_LSB    = 32;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 8;

    localparam logic ACT_ROW_WRITE = 1'b0;
    localparam logic ACT_SEARCH    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CHECK,
        ST_NB_RD,
        ST_NB_EVAL,
        ST_DONE
    } grs_state_t;

    typedef enum logic [1:0] {
        DIR_SOUTH,
        DIR_EAST,
        DIR_NORTH,
        DIR_WEST
    } grs_dir_t;

    typedef struct packed {
        logic row_write;
        logic search_start;
        logic found_clr;
        logic found_set;
        logic stack_pop;
        logic cur_load;
        logic dir_clear;
        logic dir_next;
        logic nb_read;
        logic nb_push;
        logic result_load;
    } grs_cmd_t;

    typedef struct packed {
        logic in_search;
        logic coords_ok;
        logic stack_empty;
        logic stack_full;
        logic at_end;
        logic nb_inside;
        logic nb_free;
        logic dir_last;
        logic out_busy;
    } grs_status_t;

endpackage

`default_nettype wire

// ===== sv/grid_reachability_search.sv =====
// Channel  Dir  Ports                         Word contents (low bit up)
// s_       in   s_tvalid s_tready s_tdata     row_index, row_open_bits, start_row,
//               s_tuser                       start_col, end_row, end_col; tuser: action
// m_       out  m_tvalid m_tready m_tdata     reachable
//
// Row write: done in the idle state. Search: start, then pop and check per popped cell, read
// and evaluate per in-grid neighbor, read only per neighbor off the edge, and load the result.
// Reset clears the row valid bits of both maps; there is no clearing pass.
// A finished result waits in the output register; row writes go on meanwhile, and a
// second search holds its answer until that register drains.
`default_nettype none

module grid_reachability_search #(
    parameter int GRID_ROWS = grs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = grs_pkg::GRID_COLS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // row_index[3:0], row_open_bits[19:4], start_row[23:20], start_col[27:24],
    // end_row[31:28], end_col[35:32], zero fill[39:36]
    input  wire logic [grs_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // reachable[0], zero fill[7:1]
    output logic      [grs_pkg::OUT_DATA_W-1:0]  m_tdata
);

    import grs_pkg::*;

    grs_cmd_t    cmd;
    grs_status_t status;

    grs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grs_datapath #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

`include "grid_reachability_search_assert.svh"

    `GRS_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, cmd.stack_pop, !status.stack_empty, "empty pop")
    `GRS_ASSERT_NOW(a_push_room, aclk, aresetn, cmd.nb_push, !status.stack_full, "full push")
    `GRS_ASSERT_NOW(a_result_free, aclk, aresetn, cmd.result_load, !status.out_busy, "lost word")
    `GRS_ASSERT_NEXT(a_start_seeds, aclk, aresetn, cmd.search_start, !status.stack_empty, "no seed")

endmodule

`default_nettype wire

// ===== sv/grs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module grs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/grs_ctrl.sv =====
// Search sequencer: pops cells, walks the four neighbours, issues datapath commands.
// Depends on grs_pkg.
`default_nettype none

module grs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire grs_pkg::grs_status_t status,
    output grs_pkg::grs_cmd_t         cmd
);

    import grs_pkg::*;

    grs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.in_search) begin
                    state_next = status.coords_ok ? ST_POP : ST_DONE;
                end
            end
            ST_POP: begin
                state_next = status.stack_empty ? ST_DONE : ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.at_end ? ST_DONE : ST_NB_RD;
            end
            ST_NB_RD: begin
                if (status.nb_inside) begin
                    state_next = ST_NB_EVAL;
                end else if (status.dir_last) begin
                    state_next = ST_POP;
                end
            end
            ST_NB_EVAL: begin
                state_next = status.dir_last ? ST_POP : ST_NB_RD;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!status.in_search) begin
                        cmd.row_write = 1'b1;
                    end else begin
                        cmd.found_clr    = 1'b1;
                        cmd.search_start = status.coords_ok;
                    end
                end
            end
            ST_POP: begin
                cmd.stack_pop = !status.stack_empty;
            end
            ST_CHECK: begin
                cmd.cur_load  = 1'b1;
                cmd.dir_clear = 1'b1;
                cmd.found_set = status.at_end;
            end
            ST_NB_RD: begin
                cmd.nb_read  = status.nb_inside;
                cmd.dir_next = !status.nb_inside && !status.dir_last;
            end
            ST_NB_EVAL: begin
                cmd.nb_push  = status.nb_free;
                cmd.dir_next = !status.dir_last;
            end
            ST_DONE: begin
                cmd.result_load = !status.out_busy;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/grs_datapath.sv =====
// Search datapath: open and visited row maps, cell stack, neighbor step, result register.
// Depends on grs_pkg and grs_ram.
`default_nettype none

module grs_datapath #(
    parameter int GRID_ROWS = grs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = grs_pkg::GRID_COLS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [grs_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic      [grs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire grs_pkg::grs_cmd_t               cmd,
    output grs_pkg::grs_status_t                 status
);

    import grs_pkg::*;

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int SAW   = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int EW    = RW + CW;

    // input fields
    logic [COORD_W-1:0]    f_row_index, f_start_row, f_start_col, f_end_row, f_end_col;
    logic [ROW_BITS_W-1:0] f_row_bits;

    assign f_row_index = s_tdata[ROW_INDEX_LSB +: COORD_W];
    assign f_row_bits  = s_tdata[ROW_BITS_LSB +: ROW_BITS_W];
    assign f_start_row = s_tdata[START_ROW_LSB +: COORD_W];
    assign f_start_col = s_tdata[START_COL_LSB +: COORD_W];
    assign f_end_row   = s_tdata[END_ROW_LSB +: COORD_W];
    assign f_end_col   = s_tdata[END_COL_LSB +: COORD_W];

    logic          ri_ok;
    logic [RW-1:0] sr, er;
    logic [CW-1:0] sc, ec;

    assign ri_ok = (32'(f_row_index) < GRID_ROWS);
    assign sr    = RW'(f_start_row);
    assign sc    = CW'(f_start_col);
    assign er    = RW'(f_end_row);
    assign ec    = CW'(f_end_col);

    // registers
    logic [RW-1:0]        end_row_reg, cur_row_reg;
    logic [CW-1:0]        end_col_reg, cur_col_reg;
    grs_dir_t             dir_reg;
    logic [CNTW-1:0]      count_reg;
    logic                 found_reg;
    logic                 m_valid_reg;
    logic                 reach_reg;
    logic [GRID_ROWS-1:0] open_valid_reg;
    logic [GRID_ROWS-1:0] vis_valid_reg;

    // neighbor of the current cell in the current direction
    logic          nb_inside;
    logic [RW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic [RW:0]   row_up;
    logic [CW:0]   col_up;

    assign row_up = {1'b0, cur_row_reg} + (RW+1)'(1);
    assign col_up = {1'b0, cur_col_reg} + (CW+1)'(1);

    always_comb begin
        nb_row    = cur_row_reg;
        nb_col    = cur_col_reg;
        nb_inside = 1'b0;
        case (dir_reg)
            DIR_SOUTH: begin
                nb_row    = row_up[RW-1:0];
                nb_inside = (row_up < (RW+1)'(GRID_ROWS));
            end
            DIR_EAST: begin
                nb_col    = col_up[CW-1:0];
                nb_inside = (col_up < (CW+1)'(GRID_COLS));
            end
            DIR_NORTH: begin
                nb_row    = cur_row_reg - RW'(1);
                nb_inside = (cur_row_reg != '0);
            end
            DIR_WEST: begin
                nb_col    = cur_col_reg - CW'(1);
                nb_inside = (cur_col_reg != '0);
            end
            default: nb_inside = 1'b0;
        endcase
    end

    // memories
    logic [GRID_COLS-1:0] open_rdata, vis_rdata, vis_wdata, vis_old;
    logic [RW-1:0]        vis_waddr;
    logic                 vis_we;
    logic [EW-1:0]        stack_rdata, stack_wdata;
    logic [SAW-1:0]       stack_waddr, stack_raddr;
    logic [CNTW-1:0]      pop_index;
    logic                 stack_we;

    grs_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_open_ram (
        .aclk  (aclk),
        .we    (cmd.row_write && ri_ok),
        .waddr (RW'(f_row_index)),
        .wdata (GRID_COLS'(f_row_bits)),
        .re    (cmd.nb_read),
        .raddr (nb_row),
        .rdata (open_rdata)
    );

    // a row whose valid bit is clear reads as all unvisited
    assign vis_old   = vis_valid_reg[nb_row] ? vis_rdata : '0;
    assign vis_we    = cmd.search_start || cmd.nb_push;
    assign vis_waddr = cmd.search_start ? sr : nb_row;
    assign vis_wdata = cmd.search_start ? (GRID_COLS'(1) << sc)
                                        : (vis_old | (GRID_COLS'(1) << nb_col));

    grs_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_vis_ram (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (cmd.nb_read),
        .raddr (nb_row),
        .rdata (vis_rdata)
    );

    assign pop_index   = count_reg - CNTW'(1);
    assign stack_raddr = pop_index[SAW-1:0];
    assign stack_we    = cmd.search_start || cmd.nb_push;
    assign stack_waddr = cmd.search_start ? '0 : count_reg[SAW-1:0];
    assign stack_wdata = cmd.search_start ? {sr, sc} : {nb_row, nb_col};

    grs_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (cmd.stack_pop),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg        <= DIR_SOUTH;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            open_valid_reg <= '0;
            vis_valid_reg  <= '0;
        end else begin
            if (cmd.row_write && ri_ok) begin
                open_valid_reg[RW'(f_row_index)] <= 1'b1;
            end
            if (cmd.search_start) begin
                vis_valid_reg <= GRID_ROWS'(1) << sr;
                count_reg     <= CNTW'(1);
            end else if (cmd.nb_push) begin
                vis_valid_reg[nb_row] <= 1'b1;
                count_reg             <= count_reg + CNTW'(1);
            end else if (cmd.stack_pop) begin
                count_reg <= pop_index;
            end
            if (cmd.dir_clear) begin
                dir_reg <= DIR_SOUTH;
            end else if (cmd.dir_next) begin
                dir_reg <= grs_dir_t'(dir_reg + 2'd1);
            end
            if (cmd.found_clr) begin
                found_reg <= 1'b0;
            end else if (cmd.found_set) begin
                found_reg <= 1'b1;
            end
            if (cmd.result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.search_start) begin
            end_row_reg <= er;
            end_col_reg <= ec;
        end
        if (cmd.cur_load) begin
            cur_row_reg <= stack_rdata[EW-1:CW];
            cur_col_reg <= stack_rdata[CW-1:0];
        end
        if (cmd.result_load) begin
            reach_reg <= found_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, reach_reg};

    always_comb begin
        status             = '0;
        status.in_search   = (s_tuser == ACT_SEARCH);
        status.coords_ok   = (32'(f_start_row) < GRID_ROWS) && (32'(f_start_col) < GRID_COLS)
                          && (32'(f_end_row) < GRID_ROWS) && (32'(f_end_col) < GRID_COLS);
        status.stack_empty = (count_reg == '0);
        status.stack_full  = (count_reg == CNTW'(CELLS));
        status.at_end      = (stack_rdata == {end_row_reg, end_col_reg});
        status.nb_inside   = nb_inside;
        status.nb_free     = open_valid_reg[nb_row] && open_rdata[nb_col]
                          && !(vis_old[nb_col]) && (count_reg != CNTW'(CELLS));
        status.dir_last    = (dir_reg == DIR_WEST);
        status.out_busy    = m_valid_reg && !m_tready;
    end

endmodule

`default_nettype wire

// ===== verif/grid_reachability_search_test.sv =====
// Testbench for grid_reachability_search: loads grids row by row, runs searches and
// checks each reachable flag against a flood search kept in the bench.
// Depends on grs_pkg and the grid_reachability_search top level.
module grid_reachability_search_test;
    import grs_pkg::*;

    localparam int ROWS        = GRID_ROWS_DEF;
    localparam int COLS        = GRID_COLS_DEF;
    localparam int RANDOM_CMDS = 580;
    localparam int LONG_HOLD   = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 3000;

    typedef struct {
        logic                  action;
        logic [COORD_W-1:0]    row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [COORD_W-1:0]    start_row;
        logic [COORD_W-1:0]    start_col;
        logic [COORD_W-1:0]    end_row;
        logic [COORD_W-1:0]    end_col;
        bit                    drain_first;
    } grid_cmd_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    grid_cmd_t       cmd_queue[$];
    grid_cmd_t       cur_cmd;
    bit              reach_expected[$];
    logic [COLS-1:0] open_rows [ROWS];
    logic [COLS-1:0] gen_rows [ROWS];
    bit              drain_next;
    int              total_cmds;
    int              words_sent;
    int              results_seen;
    int              error_count;
    int              burst_left;
    int              gap_left;
    int              hold_left;
    bit              long_hold_done;
    int              rx_mode;
    int              mode_left;
    int              idle_cycles;

    grid_reachability_search u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // depth-first flood, neighbors pushed south, east, north, west
    function automatic bit predict_reachable(int sr, int sc, int er, int ec);
        logic [COLS-1:0] seen [ROWS];
        int              stk_r [ROWS*COLS];
        int              stk_c [ROWS*COLS];
        int              depth;
        int              r;
        int              c;
        int              nr;
        int              nc;
        if (sr >= ROWS || sc >= COLS || er >= ROWS || ec >= COLS)
            return 1'b0;
        foreach (seen[i])
            seen[i] = '0;
        seen[sr][sc] = 1'b1;
        stk_r[0] = sr;
        stk_c[0] = sc;
        depth = 1;
        while (depth > 0) begin
            depth--;
            r = stk_r[depth];
            c = stk_c[depth];
            if (r == er && c == ec)
                return 1'b1;
            for (int d = 0; d < 4; d++) begin
                nr = r;
                nc = c;
                case (grs_dir_t'(d))
                    DIR_SOUTH: nr = r + 1;
                    DIR_EAST:  nc = c + 1;
                    DIR_NORTH: nr = r - 1;
                    default:   nc = c - 1;
                endcase
                if (nr >= 0 && nc >= 0 && nr < ROWS && nc < COLS && depth < ROWS*COLS &&
                    open_rows[nr][nc] && !seen[nr][nc]) begin
                    seen[nr][nc] = 1'b1;
                    stk_r[depth] = nr;
                    stk_c[depth] = nc;
                    depth++;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_row(input int idx, input logic [ROW_BITS_W-1:0] bits);
        grid_cmd_t cmd;
        cmd.action      = ACT_ROW_WRITE;
        cmd.row_index   = COORD_W'(idx);
        cmd.row_bits    = bits;
        // unused coordinates carry noise
        cmd.start_row   = COORD_W'($urandom);
        cmd.start_col   = COORD_W'($urandom);
        cmd.end_row     = COORD_W'($urandom);
        cmd.end_col     = COORD_W'($urandom);
        cmd.drain_first = drain_next;
        drain_next = 1'b0;
        if (idx < ROWS)
            gen_rows[idx] = bits[COLS-1:0];
        cmd_queue.push_back(cmd);
    endtask

    task automatic add_search(input int sr, input int sc, input int er, input int ec);
        grid_cmd_t cmd;
        cmd.action      = ACT_SEARCH;
        cmd.row_index   = COORD_W'($urandom);
        cmd.row_bits    = ROW_BITS_W'($urandom);
        cmd.start_row   = COORD_W'(sr);
        cmd.start_col   = COORD_W'(sc);
        cmd.end_row     = COORD_W'(er);
        cmd.end_col     = COORD_W'(ec);
        cmd.drain_first = drain_next;
        drain_next = 1'b0;
        cmd_queue.push_back(cmd);
    endtask

    function automatic logic [ROW_BITS_W-1:0] random_row(input int density);
        logic [ROW_BITS_W-1:0] bits;
        case ($urandom_range(19))
            0:       bits = '0;
            1:       bits = '1;
            default: begin
                for (int b = 0; b < ROW_BITS_W; b++)
                    bits[b] = ($urandom_range(99) < density);
            end
        endcase
        return bits;
    endfunction

    // prefer an open cell of the grid being built, fall back to any cell
    task automatic pick_cell(output int r, output int c);
        r = $urandom_range(ROWS-1);
        c = $urandom_range(COLS-1);
        for (int t = 0; t < 12 && !gen_rows[r][c]; t++) begin
            r = $urandom_range(ROWS-1);
            c = $urandom_range(COLS-1);
        end
    endtask

    initial begin : stimulus
        int densities[6];
        int density;
        int sr;
        int sc;
        int er;
        int ec;
        int scene;
        int k;
        densities = '{35, 55, 60, 65, 75, 90};
        foreach (gen_rows[i])
            gen_rows[i] = '0;
        drain_next = 1'b0;

        // all walls: start equals end still answers 1, anything else 0
        add_search(0, 0, 0, 0);
        add_search(15, 15, 0, 0);
        // top and bottom rows open, a corridor down the last column
        add_row(0, 16'hFFFF);
        add_row(15, 16'hFFFF);
        for (int r = 1; r < 15; r++)
            add_row(r, 16'h8000);
        add_search(0, 0, 15, 0);
        add_search(15, 15, 0, 0);
        // wall start with no open neighbor
        add_search(7, 0, 0, 0);
        // wall start next to the open top row
        add_search(1, 0, 15, 15);
        // cut the corridor
        add_row(7, 16'h0000);
        add_search(0, 0, 15, 0);
        add_search(15, 15, 15, 15);

        scene = 0;
        drain_next = 1'b1;
        while (cmd_queue.size() < RANDOM_CMDS) begin
            if (scene == 10)
                drain_next = 1'b1;
            density = densities[$urandom_range(5)];
            if ($urandom_range(99) < 45) begin
                for (int r = 0; r < ROWS; r++)
                    add_row(r, random_row(density));
            end else begin
                repeat ($urandom_range(1, 4))
                    add_row($urandom_range(ROWS-1), random_row(density));
            end
            repeat ($urandom_range(2, 6)) begin
                k = $urandom_range(99);
                if (k < 8) begin
                    add_row($urandom_range(ROWS-1), ROW_BITS_W'($urandom));
                end else begin
                    pick_cell(sr, sc);
                    k = $urandom_range(99);
                    if (k < 15) begin
                        er = sr;
                        ec = sc;
                    end else if (k < 70) begin
                        pick_cell(er, ec);
                    end else begin
                        er = $urandom_range(ROWS-1);
                        ec = $urandom_range(COLS-1);
                    end
                    if ($urandom_range(99) < 15) begin
                        sr = $urandom_range(ROWS-1);
                        sc = $urandom_range(COLS-1);
                    end
                    add_search(sr, sc, er, ec);
                end
            end
            scene++;
        end
        total_cmds = cmd_queue.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_sent < total_cmds || reach_expected.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && reach_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // sender: bursts of words with random gaps
    always @(posedge aclk) begin : drive_proc
        logic                 offer;
        logic [IN_DATA_W-1:0] word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            words_sent = 0;
            foreach (open_rows[i])
                open_rows[i] = '0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                offer = 1'b0;
                if (cur_cmd.action == ACT_SEARCH)
                    reach_expected.push_back(predict_reachable(
                        int'(cur_cmd.start_row), int'(cur_cmd.start_col),
                        int'(cur_cmd.end_row), int'(cur_cmd.end_col)));
                else if (cur_cmd.row_index < ROWS)
                    open_rows[cur_cmd.row_index] = cur_cmd.row_bits[COLS-1:0];
                words_sent++;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_queue.size() != 0 &&
                             !(cmd_queue[0].drain_first && reach_expected.size() != 0)) begin
                    cur_cmd = cmd_queue.pop_front();
                    word = '0;
                    word[ROW_INDEX_LSB +: COORD_W]    = cur_cmd.row_index;
                    word[ROW_BITS_LSB  +: ROW_BITS_W] = cur_cmd.row_bits;
                    word[START_ROW_LSB +: COORD_W]    = cur_cmd.start_row;
                    word[START_COL_LSB +: COORD_W]    = cur_cmd.start_col;
                    word[END_ROW_LSB   +: COORD_W]    = cur_cmd.end_row;
                    word[END_COL_LSB   +: COORD_W]    = cur_cmd.end_col;
                    s_tdata <= word;
                    s_tuser <= cur_cmd.action;
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 60);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off
    always @(posedge aclk) begin : accept_proc
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
            long_hold_done = 1'b0;
            mode_left = 0;
            rx_mode = 0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!long_hold_done && results_seen >= 20) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(2);
                    mode_left = $urandom_range(1, 150);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(1));
                    default: rdy = ($urandom_range(99) < 20);
                endcase
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin : check_proc
        bit want;
        if (!aresetn) begin
            results_seen = 0;
            error_count = 0;
        end else if (m_tvalid && m_tready) begin
            results_seen++;
            if (reach_expected.size() == 0) begin
                note_mismatch($sformatf("reachable=%0b with no search pending", m_tdata[0]));
            end else begin
                want = reach_expected.pop_front();
                if (m_tdata[0] !== want)
                    note_mismatch($sformatf("result %0d: reachable=%0b, want %0b",
                        results_seen, m_tdata[0], want));
            end
        end
    end

    // end the run if no word moves on either side for too long
    always @(posedge aclk) begin : watchdog_proc
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no word moved for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
